FILE: src/ntms_pkg.sv
// shared types and constants for the nearest three mark selector
// no dependencies

package ntms_pkg;

    // configuration register indexes
    localparam int unsigned REG_MARK_COUNT = 0;
    localparam int unsigned REG_MAP_VALID  = 1;
    localparam int unsigned CFG_IDX_BITS   = 1;
    localparam int unsigned CFG_DATA_BITS  = 7;

    // item field widths
    localparam int unsigned IDX_BITS   = 6;
    localparam int unsigned FIELD_BITS = 24;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_EVAL,
        ST_NEXT,
        ST_DONE,
        ST_SQ,
        ST_TEST
    } ntms_state_t;

endpackage

FILE: src/ntms_if.sv
// valid/ready channel interface
// depends on nothing; payload width is a parameter

interface ntms_if #(
    parameter int unsigned W = 8
);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: src/ntms_mark_ram.sv
// mark table memory: nominal and stage coordinates and found flag
// depends on ntms_pkg

module ntms_mark_ram #(
    parameter int unsigned DEPTH = 64,
    parameter int unsigned CW    = 24,
    parameter int unsigned AW    = 6
) (
    input  logic                 clk,
    input  logic                 we,
    input  logic [AW-1:0]        waddr,
    input  logic [4*CW:0]        wdata,
    input  logic [AW-1:0]        raddr,
    output logic [4*CW:0]        rdata
);
    import ntms_pkg::*;

    logic [4*CW:0] mem [DEPTH];

    // single write port, registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

FILE: src/nearest_three_mark_selector.sv
// top level of the nearest three mark selector
// depends on ntms_pkg, ntms_if, ntms_mark_ram
//
// Usage: configuration writes set mark_count (index 0) and map_valid
// (index 1) while the block is idle. Input items arrive on in_ch, one
// result item leaves on out_ch per input item.
// A store item writes one table entry; its result is valid the cycle
// after the item is accepted. A query with map_valid low fails the same way.
// A query scans the table three times; each entry visit is a memory read,
// the shared difference and product unit and a compare. Between the second
// and third scans the first two picks are read back. In the third scan a
// mark nearer than the best so far and not collinear with the first two
// picks also runs the sine test: squaring on one half-width multiplier and
// a compare. Each scan covers the first min(mark_count, MAX_MARKS) entries;
// a query that fails a scan ends at that scan.
// The block takes one item at a time; in_ch.ready is low while an item
// is at work or its result is held. The result register holds until
// out_ch.ready; a stalled receiver stalls the block and nothing is lost.
// Reset clears the config registers and control state, not the datapath or table.

module nearest_three_mark_selector #(
    parameter int unsigned MAX_MARKS  = 64,
    parameter int unsigned COORD_BITS = 24
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [ntms_pkg::CFG_IDX_BITS-1:0] cfg_index,
    input  logic [ntms_pkg::CFG_DATA_BITS-1:0] cfg_data,
    ntms_if.sink                              in_ch,
    ntms_if.source                            out_ch
);
    import ntms_pkg::*;

    localparam int unsigned AW = (MAX_MARKS > 1) ? $clog2(MAX_MARKS) : 1;
    localparam int unsigned CW = COORD_BITS;
    localparam int unsigned DW = CW + 1;           // differences
    localparam int unsigned PW = 2 * DW + 2;       // products, sums
    localparam int unsigned HW = PW / 2;           // multiplier operand halves
    localparam int unsigned QW = 2 * PW + 2;       // squared products
    localparam int unsigned NW = AW + 1;

    // input field unpack: mode space idx px py sx sy found
    logic              f_mode, f_space, f_found;
    logic [IDX_BITS-1:0] f_idx;
    logic signed [FIELD_BITS-1:0] f_px, f_py, f_sx, f_sy;
    assign {f_mode, f_space, f_idx, f_px, f_py, f_sx, f_sy, f_found} = in_ch.data;

    // configuration registers
    logic [6:0] mark_count_reg;
    logic       map_valid_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mark_count_reg <= '0;
            map_valid_reg  <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_IDX_BITS'(REG_MARK_COUNT): mark_count_reg <= cfg_data;
                CFG_IDX_BITS'(REG_MAP_VALID):  map_valid_reg  <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // coordinate truncation to COORD_BITS
    function automatic logic signed [CW-1:0] cut(input logic [FIELD_BITS-1:0] v);
        logic [31:0] t;
        t = 32'(signed'(v));
        return t[CW-1:0];
    endfunction

    // mark memory
    logic            ram_we;
    logic [AW-1:0]   ram_raddr, ram_waddr;
    logic [4*CW:0]   ram_wdata, ram_rdata;
    assign ram_wdata = {cut(f_px), cut(f_py), cut(f_sx), cut(f_sy), f_found};
    assign ram_waddr = AW'(f_idx);

    ntms_mark_ram #(.DEPTH(MAX_MARKS), .CW(CW), .AW(AW)) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // sequencer registers
    ntms_state_t state_reg, state_next;
    logic [1:0]  pass_reg, pass_next;       // 0,1,2 scans; 3 reading picks
    logic [NW-1:0] i_reg, i_next;
    logic [NW-1:0] n_reg, n_next;
    logic        space_reg, space_next;
    logic signed [CW-1:0] qx_reg, qx_next, qy_reg, qy_next;
    logic [AW-1:0] pick0_reg, pick0_next, pick1_reg, pick1_next, best_reg, best_next;
    logic        have_reg, have_next;
    logic [PW-1:0] bestd_reg, bestd_next;
    logic signed [CW-1:0] ax_reg, ax_next, ay_reg, ay_next, bx_reg, bx_next, by_reg, by_next;
    logic [1:0]  load_reg, load_next;       // pick reload step before third pass
    logic [3*IDX_BITS:0] out_reg, out_next;
    logic        out_valid_reg, out_valid_next;
    logic [2:0]  sq_step_reg, sq_step_next;
    logic [QW-1:0] csq_reg, csq_next, dsq_reg, dsq_next;

    // current entry from memory
    logic signed [CW-1:0] ex, ey;
    logic                 efound;
    assign ex = space_reg ? ram_rdata[2*CW:CW+1] : ram_rdata[4*CW:3*CW+1];
    assign ey = space_reg ? ram_rdata[CW:1] : ram_rdata[3*CW:2*CW+1];
    assign efound = ram_rdata[0];

    // shared arithmetic unit, stage 1: differences, squared distance, cross and dot products
    logic signed [DW-1:0] dx, dy, vx, vy, wx, wy;
    logic signed [PW-1:0] d2, cr, dt;
    always_comb
    begin
        dx = DW'(ex) - DW'(qx_reg);
        dy = DW'(ey) - DW'(qy_reg);
        vx = DW'(bx_reg) - DW'(ax_reg);
        vy = DW'(by_reg) - DW'(ay_reg);
        wx = DW'(ex) - DW'(bx_reg);
        wy = DW'(ey) - DW'(by_reg);
    end

    logic signed [PW-1:0] d2_reg, cr_reg, dt_reg;
    logic                 skip_reg;
    logic [AW-1:0]        cur_reg;
    always_comb
    begin
        d2 = PW'(dx * dx) + PW'(dy * dy);
        cr = PW'(wx * vy) - PW'(wy * vx);
        dt = PW'(wx * vx) + PW'(wy * vy);
    end

    // stage 2: squares for the sine test, one half-width product a cycle
    logic [PW-1:0] cmag, dmag;
    logic [HW-1:0] sq_a, sq_b;
    logic [PW-1:0] sq_prod;
    logic [QW-1:0] sq_term;
    always_comb
    begin
        cmag = cr_reg[PW-1] ? -cr_reg : cr_reg;
        dmag = dt_reg[PW-1] ? -dt_reg : dt_reg;
        case (sq_step_reg)
            3'd0:
            begin
                sq_a = cmag[PW-1:HW];
                sq_b = cmag[PW-1:HW];
            end
            3'd1:
            begin
                sq_a = cmag[PW-1:HW];
                sq_b = cmag[HW-1:0];
            end
            3'd2:
            begin
                sq_a = cmag[HW-1:0];
                sq_b = cmag[HW-1:0];
            end
            3'd3:
            begin
                sq_a = dmag[PW-1:HW];
                sq_b = dmag[PW-1:HW];
            end
            3'd4:
            begin
                sq_a = dmag[PW-1:HW];
                sq_b = dmag[HW-1:0];
            end
            default:
            begin
                sq_a = dmag[HW-1:0];
                sq_b = dmag[HW-1:0];
            end
        endcase
        sq_prod = sq_a * sq_b;
        // high by high, twice the cross term, low by low
        case (sq_step_reg)
            3'd0, 3'd3: sq_term = QW'(sq_prod) << (2 * HW);
            3'd1, 3'd4: sq_term = QW'(sq_prod) << (HW + 1);
            default:    sq_term = QW'(sq_prod);
        endcase
    end

    logic [AW-1:0] i_lo;
    assign i_lo = i_reg[AW-1:0];

    always_comb
    begin
        state_next     = state_reg;
        pass_next      = pass_reg;
        i_next         = i_reg;
        n_next         = n_reg;
        space_next     = space_reg;
        qx_next        = qx_reg;
        qy_next        = qy_reg;
        pick0_next     = pick0_reg;
        pick1_next     = pick1_reg;
        best_next      = best_reg;
        have_next      = have_reg;
        bestd_next     = bestd_reg;
        ax_next        = ax_reg;
        ay_next        = ay_reg;
        bx_next        = bx_reg;
        by_next        = by_reg;
        load_next      = load_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        sq_step_next   = sq_step_reg;
        csq_next       = csq_reg;
        dsq_next       = dsq_reg;
        ram_we         = 1'b0;
        ram_raddr      = i_lo;
        in_ch.ready    = 1'b0;

        if (out_valid_reg && out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                in_ch.ready = !out_valid_reg;
                if (in_ch.valid && !out_valid_reg)
                begin
                    if (!f_mode)
                    begin
                        ram_we         = (32'(f_idx) < MAX_MARKS);
                        out_next       = {ram_we, {(3*IDX_BITS){1'b0}}};
                        out_valid_next = 1'b1;
                    end
                    else
                    begin
                        space_next = f_space;
                        qx_next    = cut(f_px);
                        qy_next    = cut(f_py);
                        n_next     = (32'(mark_count_reg) < MAX_MARKS) ?
                                     NW'(mark_count_reg) : NW'(MAX_MARKS);
                        pass_next  = 2'd0;
                        i_next     = '0;
                        have_next  = 1'b0;
                        if (!map_valid_reg)
                        begin
                            out_next       = '0;
                            out_valid_next = 1'b1;
                        end
                        else
                        begin
                            state_next = ST_READ;
                        end
                    end
                end
            end
            ST_READ:
            begin
                // address presented, data valid next cycle
                if (pass_reg == 2'd3)
                begin
                    ram_raddr = load_reg[0] ? pick1_reg : pick0_reg;
                    state_next = ST_EVAL;
                end
                else if (i_reg >= n_reg)
                begin
                    state_next = ST_NEXT;
                end
                else
                begin
                    ram_raddr  = i_lo;
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                if (pass_reg == 2'd3)
                begin
                    if (!load_reg[0])
                    begin
                        ax_next = ex; ay_next = ey;
                        load_next = 2'd1;
                        state_next = ST_READ;
                    end
                    else
                    begin
                        bx_next = ex; by_next = ey;
                        pass_next = 2'd2;
                        i_next = '0;
                        have_next = 1'b0;
                        state_next = ST_READ;
                    end
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                // distance compare; third scan sends a nearer non-collinear mark to the sine test
                i_next     = i_reg + NW'(1);
                state_next = ST_READ;
                if (!skip_reg && (!have_reg || d2_reg < bestd_reg))
                begin
                    if (pass_reg != 2'd2)
                    begin
                        have_next  = 1'b1;
                        best_next  = cur_reg;
                        bestd_next = d2_reg;
                    end
                    else if (cr_reg != '0)
                    begin
                        i_next       = i_reg;
                        sq_step_next = 3'd0;
                        csq_next     = '0;
                        dsq_next     = '0;
                        state_next   = ST_SQ;
                    end
                end
            end
            ST_SQ:
            begin
                // accumulate cross product squared, then dot product squared
                if (sq_step_reg < 3'd3)
                begin
                    csq_next = csq_reg + sq_term;
                end
                else
                begin
                    dsq_next = dsq_reg + sq_term;
                end
                sq_step_next = sq_step_reg + 3'd1;
                if (sq_step_reg == 3'd5)
                begin
                    state_next = ST_TEST;
                end
            end
            ST_TEST:
            begin
                // sine of at least one half: 3*c*c >= d*d
                if ((csq_reg << 1) + csq_reg >= dsq_reg)
                begin
                    have_next  = 1'b1;
                    best_next  = cur_reg;
                    bestd_next = d2_reg;
                end
                i_next     = i_reg + NW'(1);
                state_next = ST_READ;
            end
            ST_NEXT:
            begin
                if (!have_reg)
                begin
                    out_next       = '0;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
                else if (pass_reg == 2'd0)
                begin
                    pick0_next = best_reg;
                    pass_next  = 2'd1;
                    i_next     = '0;
                    have_next  = 1'b0;
                    state_next = ST_READ;
                end
                else if (pass_reg == 2'd1)
                begin
                    pick1_next = best_reg;
                    pass_next  = 2'd3;
                    load_next  = 2'd0;
                    state_next = ST_READ;
                end
                else
                begin
                    out_next = {1'b1, IDX_BITS'(pick0_reg), IDX_BITS'(pick1_reg),
                                IDX_BITS'(best_reg)};
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // product registers of the shared unit
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_EVAL)
        begin
            d2_reg   <= d2;
            cr_reg   <= cr;
            dt_reg   <= dt;
            cur_reg  <= i_lo;
            skip_reg <= !efound ||
                        (pass_reg != 2'd0 && i_lo == pick0_reg) ||
                        (pass_reg == 2'd2 && i_lo == pick1_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            pass_reg      <= '0;
            i_reg         <= '0;
            have_reg      <= 1'b0;
            load_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            pass_reg      <= pass_next;
            i_reg         <= i_next;
            have_reg      <= have_next;
            load_reg      <= load_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg       <= n_next;
        space_reg   <= space_next;
        qx_reg      <= qx_next;
        qy_reg      <= qy_next;
        pick0_reg   <= pick0_next;
        pick1_reg   <= pick1_next;
        best_reg    <= best_next;
        bestd_reg   <= bestd_next;
        ax_reg      <= ax_next;
        ay_reg      <= ay_next;
        bx_reg      <= bx_next;
        by_reg      <= by_next;
        sq_step_reg <= sq_step_next;
        csq_reg     <= csq_next;
        dsq_reg     <= dsq_next;
        out_reg     <= out_next;
    end

    assign out_ch.valid = out_valid_reg;
    assign out_ch.data  = out_reg;

    // no new item is taken while a result waits
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !in_ch.ready)
        else $error("input taken while result pending");

    // a held result stays until taken
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_ch.ready |=> out_valid_reg && $stable(out_reg))
        else $error("result dropped under stall");

    // a successful query with a nonzero third index never repeats its first pick as second
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg[3*IDX_BITS] && out_reg[IDX_BITS-1:0] != '0 |->
        out_reg[3*IDX_BITS-1:2*IDX_BITS] != out_reg[2*IDX_BITS-1:IDX_BITS])
        else $error("first and second pick equal");
endmodule

FILE: bench/tb_ntms_if_note.sv
`timescale 1ns / 100ps
// item layouts used by the selector bench on the in_ch and out_ch payloads
// depends on ntms_pkg; the channel interface itself comes from src/ntms_if.sv

package tb_ntms_types;

    import ntms_pkg::*;

    // input item, first field in the top bits
    typedef struct packed {
        logic                         mode;
        logic                         space;
        logic [IDX_BITS-1:0]          mark_index;
        logic signed [FIELD_BITS-1:0] pos_x;
        logic signed [FIELD_BITS-1:0] pos_y;
        logic signed [FIELD_BITS-1:0] stage_x;
        logic signed [FIELD_BITS-1:0] stage_y;
        logic                         mark_found;
    } mark_item_t;

    // result item
    typedef struct packed {
        logic                success;
        logic [IDX_BITS-1:0] first_index;
        logic [IDX_BITS-1:0] second_index;
        logic [IDX_BITS-1:0] third_index;
    } pick_item_t;

    typedef enum logic { OP_STORE = 1'b0, OP_QUERY = 1'b1 } op_t;
    typedef enum logic { SP_NOMINAL = 1'b0, SP_STAGE = 1'b1 } space_t;

endpackage

FILE: bench/tb_nearest_three_mark_selector.sv
`timescale 1ns / 100ps
// bench for nearest_three_mark_selector: store and query items with random pacing,
// results checked against a built-in model of the mark picks
// depends on ntms_pkg, ntms_if, tb_ntms_types and the selector RTL

module tb_nearest_three_mark_selector;

    import ntms_pkg::*;
    import tb_ntms_types::*;

    localparam int NMARKS     = 64;
    localparam int STALL_MAX  = 8;
    localparam int WATCH_MAX  = 6000;

    typedef logic signed [127:0] wide_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_BITS-1:0] cfg_index;
    logic [CFG_DATA_BITS-1:0] cfg_data;

    ntms_if #(.W($bits(mark_item_t))) in_ch ();
    ntms_if #(.W($bits(pick_item_t))) out_ch ();

    nearest_three_mark_selector uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    // mirror of the mark table and registers
    logic signed [FIELD_BITS-1:0] nom_x [NMARKS];
    logic signed [FIELD_BITS-1:0] nom_y [NMARKS];
    logic signed [FIELD_BITS-1:0] stg_x [NMARKS];
    logic signed [FIELD_BITS-1:0] stg_y [NMARKS];
    logic                         found_mirror [NMARKS];
    int unsigned mark_count_mirror;
    logic        map_valid_mirror;

    mark_item_t pending_items [$];
    pick_item_t expected_picks [$];
    int error_count;
    int idle_cycles;

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic report(input string what);
        begin
            $display("MISMATCH at %0t: %s", $realtime, what);
            error_count++;
        end
    endtask

    // point of one mark in the chosen space
    function automatic void mark_point(input int i, input logic sp,
                                       output wide_t x, output wide_t y);
        begin
            x = sp ? wide_t'(stg_x[i]) : wide_t'(nom_x[i]);
            y = sp ? wide_t'(stg_y[i]) : wide_t'(nom_y[i]);
        end
    endfunction

    // sine of the turn at b is at least one half: 3*c*c >= d*d, c nonzero
    function automatic bit turn_wide_enough(input int a, input int b, input int c,
                                            input logic sp);
        wide_t ax, ay, bx, by, cx, cy, vx, vy, wx, wy, cr, dt;
        begin
            mark_point(a, sp, ax, ay);
            mark_point(b, sp, bx, by);
            mark_point(c, sp, cx, cy);
            vx = bx - ax; vy = by - ay;
            wx = cx - bx; wy = cy - by;
            cr = wx * vy - wy * vx;
            dt = wx * vx + wy * vy;
            if (cr == 0)
                return 1'b0;
            return (3 * cr * cr) >= (dt * dt);
        end
    endfunction

    // apply one item to the mirror and give the result it should cause
    function automatic pick_item_t pick_nearest_marks(input mark_item_t it);
        pick_item_t r;
        int n, pick [3], best;
        bit have;
        wide_t qx, qy, px, py, d2, bestd;
        begin
            r = '0;
            if (op_t'(it.mode) == OP_STORE) begin
                nom_x[it.mark_index] = it.pos_x;
                nom_y[it.mark_index] = it.pos_y;
                stg_x[it.mark_index] = it.stage_x;
                stg_y[it.mark_index] = it.stage_y;
                found_mirror[it.mark_index] = it.mark_found;
                r.success = 1'b1;
                return r;
            end
            if (!map_valid_mirror)
                return r;
            n = (mark_count_mirror < NMARKS) ? mark_count_mirror : NMARKS;
            qx = wide_t'(it.pos_x);
            qy = wide_t'(it.pos_y);
            for (int j = 0; j < 3; j++) begin
                have = 1'b0;
                best = 0;
                bestd = 0;
                for (int i = 0; i < n; i++) begin
                    if (!found_mirror[i])
                        continue;
                    if ((j > 0 && pick[0] == i) || (j > 1 && pick[1] == i))
                        continue;
                    mark_point(i, it.space, px, py);
                    d2 = (px - qx) * (px - qx) + (py - qy) * (py - qy);
                    if (have && d2 >= bestd)
                        continue;
                    if (j == 2 && !turn_wide_enough(pick[0], pick[1], i, it.space))
                        continue;
                    have = 1'b1;
                    best = i;
                    bestd = d2;
                end
                if (!have)
                    return r;
                pick[j] = best;
            end
            r.success = 1'b1;
            r.first_index = pick[0][5:0];
            r.second_index = pick[1][5:0];
            r.third_index = pick[2][5:0];
            return r;
        end
    endfunction

    // idle draw with stretches of no idling
    function automatic int draw_wait();
        begin
            if ($urandom_range(0, 3) == 0)
                return 0;
            return $urandom_range(0, STALL_MAX);
        end
    endfunction

    // input driver
    int send_gap;
    always @(posedge clk or negedge rst_n) begin
        logic next_valid;
        if (!rst_n) begin
            in_ch.valid <= 1'b0;
            in_ch.data <= '0;
            send_gap = 0;
        end else begin
            next_valid = in_ch.valid;
            if (in_ch.valid && in_ch.ready) begin
                expected_picks.push_back(pick_nearest_marks(mark_item_t'(in_ch.data)));
                next_valid = 1'b0;
                send_gap = draw_wait();
            end
            if (!next_valid) begin
                if (send_gap > 0)
                    send_gap--;
                else if (pending_items.size() > 0) begin
                    in_ch.data <= pending_items.pop_front();
                    next_valid = 1'b1;
                end
            end
            in_ch.valid <= next_valid;
        end
    end

    // result monitor
    int recv_stall;
    always @(posedge clk or negedge rst_n) begin
        pick_item_t got, want;
        if (!rst_n) begin
            out_ch.ready <= 1'b0;
            recv_stall = 0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                got = pick_item_t'(out_ch.data);
                if (expected_picks.size() == 0)
                    report("result item with nothing expected");
                else begin
                    want = expected_picks.pop_front();
                    if (got.success !== want.success)
                        report($sformatf("success %b, want %b", got.success, want.success));
                    if (got.first_index !== want.first_index)
                        report($sformatf("first_index %0d, want %0d",
                                         got.first_index, want.first_index));
                    if (got.second_index !== want.second_index)
                        report($sformatf("second_index %0d, want %0d",
                                         got.second_index, want.second_index));
                    if (got.third_index !== want.third_index)
                        report($sformatf("third_index %0d, want %0d",
                                         got.third_index, want.third_index));
                end
                recv_stall = draw_wait();
            end
            else if (recv_stall > 0)
                recv_stall--;
            out_ch.ready <= (recv_stall == 0);
        end
    end

    // watchdog on cycles with no handshake
    always @(posedge clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || cfg_we)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCH_MAX) begin
            $display("tb_nearest_three_mark_selector: done, errors");
            $finish;
        end
    end

    task automatic write_reg(input int unsigned idx, input int unsigned value);
        begin
            @(posedge clk);
            cfg_we <= 1'b1;
            cfg_index <= idx[CFG_IDX_BITS-1:0];
            cfg_data <= value[CFG_DATA_BITS-1:0];
            if (idx == REG_MARK_COUNT)
                mark_count_mirror = value;
            else
                map_valid_mirror = value[0];
            @(posedge clk);
            cfg_we <= 1'b0;
        end
    endtask

    task automatic wait_drained();
        begin
            while (pending_items.size() > 0 || in_ch.valid || expected_picks.size() > 0)
                @(posedge clk);
            repeat (4) @(posedge clk);
        end
    endtask

    // coordinate mix: extremes, full range, mostly a small cluster
    function automatic logic signed [FIELD_BITS-1:0] rand_coord();
        begin
            case ($urandom_range(0, 9))
                0: return 24'sh7FFFFF;
                1: return -24'sh800000;
                2, 3: return FIELD_BITS'($urandom());
                default: return $signed(24'($urandom_range(0, 80))) - 24'sd40;
            endcase
        end
    endfunction

    function automatic mark_item_t make_store(input int idx, input logic fnd);
        mark_item_t it;
        begin
            it = '0;
            it.mode = OP_STORE;
            it.space = 1'($urandom_range(0, 1));
            it.mark_index = idx[5:0];
            it.pos_x = rand_coord();
            it.pos_y = rand_coord();
            it.stage_x = rand_coord();
            it.stage_y = rand_coord();
            it.mark_found = fnd;
            return it;
        end
    endfunction

    function automatic mark_item_t make_query(input logic sp);
        mark_item_t it;
        begin
            it = '0;
            it.mark_index = IDX_BITS'($urandom());
            it.stage_x = FIELD_BITS'($urandom());
            it.stage_y = FIELD_BITS'($urandom());
            it.mark_found = 1'($urandom());
            it.mode = OP_QUERY;
            it.space = sp;
            it.pos_x = rand_coord();
            it.pos_y = rand_coord();
            return it;
        end
    endfunction

    function automatic mark_item_t place_mark(input int idx, input int x, input int y,
                                              input logic fnd);
        mark_item_t it;
        begin
            it = '0;
            it.mode = OP_STORE;
            it.mark_index = idx[5:0];
            it.pos_x = FIELD_BITS'(x); it.pos_y = FIELD_BITS'(y);
            it.stage_x = FIELD_BITS'(-x); it.stage_y = FIELD_BITS'(y);
            it.mark_found = fnd;
            return it;
        end
    endfunction

    initial begin
        mark_item_t q;
        int unsigned cnt;
        error_count = 0;
        mark_count_mirror = 0;
        map_valid_mirror = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        rst_n = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // every register at its reset value, then fill the whole table
        write_reg(REG_MARK_COUNT, 0);
        write_reg(REG_MAP_VALID, 0);
        for (int i = 0; i < NMARKS; i++)
            pending_items.push_back(make_store(i, 1'($urandom_range(0, 1))));
        // query against an invalid map fails
        pending_items.push_back(make_query(SP_NOMINAL));
        wait_drained();

        // empty scan and too few marks
        write_reg(REG_MAP_VALID, 1);
        pending_items.push_back(make_query(SP_STAGE));
        wait_drained();
        write_reg(REG_MARK_COUNT, 2);
        pending_items.push_back(place_mark(0, 0, 0, 1));
        pending_items.push_back(place_mark(1, 10, 0, 1));
        pending_items.push_back(make_query(SP_NOMINAL));
        wait_drained();

        // collinear third candidate fails the angle test; ties; unfound mark
        write_reg(REG_MARK_COUNT, 6);
        pending_items.push_back(place_mark(2, 20, 0, 1));
        pending_items.push_back(place_mark(3, 10, 0, 1));
        pending_items.push_back(place_mark(4, 10, 10, 0));
        pending_items.push_back(place_mark(5, 0, 0, 1));
        q = make_query(SP_NOMINAL); q.pos_x = '0; q.pos_y = '0;
        pending_items.push_back(q);
        q.space = SP_STAGE;
        pending_items.push_back(q);
        pending_items.push_back(place_mark(4, 10, 10, 1));
        pending_items.push_back(q);
        q.space = SP_NOMINAL; q.pos_x = 24'sh7FFFFF; q.pos_y = -24'sh800000;
        pending_items.push_back(q);
        pending_items.push_back(place_mark(2, 8388607, -8388608, 1));
        pending_items.push_back(place_mark(3, -8388608, 8388607, 1));
        pending_items.push_back(q);
        q.pos_x = -24'sh800000; q.pos_y = 24'sh7FFFFF; q.space = SP_STAGE;
        pending_items.push_back(q);
        wait_drained();

        // full table and count equal to the table depth
        write_reg(REG_MARK_COUNT, 64);
        for (int i = 0; i < 4; i++)
            pending_items.push_back(make_query(i[0]));
        wait_drained();

        // random phases, mostly small tables
        for (int ph = 0; ph < 14; ph++) begin
            case ($urandom_range(0, 9))
                0: cnt = 64;
                1: cnt = $urandom_range(0, 2);
                default: cnt = $urandom_range(3, 12);
            endcase
            write_reg(REG_MARK_COUNT, cnt);
            write_reg(REG_MAP_VALID, ($urandom_range(0, 7) != 0));
            for (int k = 0; k < 100; k++) begin
                if ($urandom_range(0, 2) == 0)
                    pending_items.push_back(make_store(
                        ($urandom_range(0, 4) == 0) ? $urandom_range(0, 63)
                                                    : $urandom_range(0, (cnt > 0) ? cnt - 1 : 0),
                        ($urandom_range(0, 4) != 0)));
                else
                    pending_items.push_back(make_query(1'($urandom_range(0, 1))));
            end
            wait_drained();
        end

        repeat (20) @(posedge clk);
        if (error_count == 0)
            $display("tb_nearest_three_mark_selector: done, clean");
        else
            $display("tb_nearest_three_mark_selector: done, errors");
        $finish;
    end

endmodule

FILE: filelist.f
src/ntms_pkg.sv
src/ntms_if.sv
src/ntms_mark_ram.sv
src/nearest_three_mark_selector.sv
bench/tb_ntms_if_note.sv
bench/tb_nearest_three_mark_selector.sv
